@@ sv/mtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

	localparam int SECONDS_W = 32;
	localparam int YEAR_W    = 11;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int WEEKDAY_W = 3;
	localparam int HOUR_W    = 5;
	localparam int MINUTE_W  = 6;
	localparam int SECOND_W  = 6;
	localparam int SHIFT_W   = 5;

	localparam int DAYS_W    = 16;  // whole days, below 49711
	localparam int SOD_W     = 17;  // seconds of the day, below 86400
	localparam int REST_W    = 12;  // seconds of the hour, below 3600
	localparam int CYCLE_W   = 6;   // four-year cycles, below 35
	localparam int REM_W     = 11;  // day within a four-year span, below 1461
	localparam int DOY_W     = 9;   // day within a year, below 366

	localparam int OUT_DATA_W = 40;

	localparam int unsigned SECS_PER_DAY   = 86400;
	localparam int unsigned SECS_PER_HOUR  = 3600;
	localparam int unsigned SECS_PER_MIN   = 60;
	localparam int unsigned DAYS_PER_CYCLE = 1461;
	localparam int unsigned DAYS_PER_WEEK  = 7;
	localparam int unsigned HOURS_PER_DAY  = 24;
	localparam int unsigned YEAR3_START    = 1096;
	localparam int unsigned YEAR2_START    = 731;
	localparam int unsigned YEAR1_START    = 366;
	localparam int unsigned YEAR_BASE      = 1904;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd1;

	// reciprocal multipliers, exact over the operand ranges above
	// t/86400 == ((t >> 7) * RCP_DAY) >> 35
	localparam logic [25:0] RCP_DAY   = 26'd50903317;
	localparam int          SH_DAY    = 35;
	localparam logic [16:0] RCP_CYCLE = 17'd91868;
	localparam int          SH_CYCLE  = 27;
	localparam logic [16:0] RCP_WEEK  = 17'd74899;
	localparam int          SH_WEEK   = 19;
	localparam logic [17:0] RCP_HOUR  = 18'd149131;
	localparam int          SH_HOUR   = 29;
	localparam logic [12:0] RCP_MIN   = 13'd4370;
	localparam int          SH_MIN    = 18;

	typedef logic [DOY_W-1:0] doy_t;
	typedef doy_t [11:0] month_tbl_t;

	localparam month_tbl_t COMMON_FIRST = '{
		9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
		9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
	};
	localparam month_tbl_t LEAP_FIRST = '{
		9'd335, 9'd305, 9'd274, 9'd244, 9'd213, 9'd182,
		9'd152, 9'd121, 9'd91,  9'd60,  9'd31,  9'd0
	};

endpackage

`default_nettype wire

@@ sv/mac_timestamp_to_calendar_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Each accepted input beat is registered through stages s1 to s6 before it leaves as its output beat.
// Throughput: one beat per cycle; six pipeline stages split the constant
// divisions into reciprocal multiplies with the remainder fixups a stage later.
// Stalls: the whole pipeline holds while the output beat waits.
// Reset (arst_n, asynchronous): clears all stage valid bits and sets hour_shift to 1.
module mac_timestamp_to_calendar_top (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [mtc_pkg::SHIFT_W-1:0]       cfg_data,     // hour_shift
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [mtc_pkg::SECONDS_W-1:0]     s_tdata,      // [31:0] mac_seconds
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// [10:0] year, [14:11] month, [19:15] day, [22:20] weekday,
	// [27:23] hour, [33:28] minute, [39:34] second
	output logic [mtc_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import mtc_pkg::*;

	logic [SHIFT_W-1:0] hour_shift_q;
	logic               en;
	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic [SECONDS_W-1:0] t_s1;
	logic [50:0]          day_prod_s1;
	logic [DAYS_W-1:0]    days_s2;
	logic [SOD_W-1:0]     secs_s2;
	logic [SOD_W-1:0]     secs_s3;
	logic [34:0]          hh_prod_s3;
	logic [HOUR_W-1:0]    hh_s4;
	logic [REST_W-1:0]    rest_s4;
	logic [HOUR_W-1:0]    hour_s5;
	logic [REST_W-1:0]    rest_s5;
	logic [24:0]          mm_prod_s5;
	logic [HOUR_W-1:0]    hour_s6;
	logic [MINUTE_W-1:0]  minute_s6;
	logic [SECOND_W-1:0]  second_s6;

	logic [DAYS_W-1:0]    days_c;
	logic [SECONDS_W-1:0] secs_full_c;
	logic [HOUR_W-1:0]    hh_c;
	logic [SOD_W-1:0]     rest_full_c;
	logic [5:0]           hsum_c;
	logic [5:0]           hour_full_c;
	logic [MINUTE_W-1:0]  mm_c;
	logic [REST_W-1:0]    ss_full_c;

	logic [YEAR_W-1:0]    year;
	logic [MONTH_W-1:0]   month;
	logic [DAY_W-1:0]     day;
	logic [WEEKDAY_W-1:0] weekday;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_shift_q <= SHIFT_RESET;
		end else if (cfg_valid) begin
			hour_shift_q <= cfg_data;
		end
	end

	// advance every stage unless the output beat is held
	assign en       = !valid_s6 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1        <= s_tdata;
			day_prod_s1 <= 51'(s_tdata[SECONDS_W-1:7]) * 51'(RCP_DAY);
		end
	end

	always_comb begin
		days_c      = day_prod_s1[SH_DAY +: DAYS_W];
		secs_full_c = t_s1 - SECONDS_W'(days_c) * SECONDS_W'(SECS_PER_DAY);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s2 <= days_c;
			secs_s2 <= secs_full_c[SOD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			secs_s3    <= secs_s2;
			hh_prod_s3 <= 35'(secs_s2) * 35'(RCP_HOUR);
		end
	end

	always_comb begin
		hh_c        = hh_prod_s3[SH_HOUR +: HOUR_W];
		rest_full_c = secs_s3 - SOD_W'(hh_c) * SOD_W'(SECS_PER_HOUR);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s4   <= hh_c;
			rest_s4 <= rest_full_c[REST_W-1:0];
		end
	end

	// sum is at most 54, so subtracting 48 or 24 brings it below 24
	always_comb begin
		hsum_c = {1'b0, hh_s4} + {1'b0, hour_shift_q};
		priority if (hsum_c >= 6'(2 * HOURS_PER_DAY))
			hour_full_c = hsum_c - 6'(2 * HOURS_PER_DAY);
		else if (hsum_c >= 6'(HOURS_PER_DAY))
			hour_full_c = hsum_c - 6'(HOURS_PER_DAY);
		else
			hour_full_c = hsum_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s5    <= hour_full_c[HOUR_W-1:0];
			rest_s5    <= rest_s4;
			mm_prod_s5 <= 25'(rest_s4) * 25'(RCP_MIN);
		end
	end

	always_comb begin
		mm_c      = mm_prod_s5[SH_MIN +: MINUTE_W];
		ss_full_c = rest_s5 - REST_W'(mm_c) * REST_W'(SECS_PER_MIN);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s6   <= hour_s5;
			minute_s6 <= mm_c;
			second_s6 <= ss_full_c[SECOND_W-1:0];
		end
	end

	mtc_date_split u_date (
		.clk     (clk),
		.en      (en),
		.days    (days_s2),
		.year    (year),
		.month   (month),
		.day     (day),
		.weekday (weekday)
	);

	assign m_tvalid = valid_s6;
	assign m_tdata  = {second_s6, minute_s6, hour_s6, weekday, day, month, year};

endmodule

`default_nettype wire

@@ sv/mtc_date_split.sv @@
`timescale 1ns / 1ps
`default_nettype none

// days since the epoch to year, month, day of month and weekday; four stages
module mtc_date_split (
	input  wire                               clk,
	input  wire                               en,
	input  wire  [mtc_pkg::DAYS_W-1:0]        days,
	output logic [mtc_pkg::YEAR_W-1:0]        year,
	output logic [mtc_pkg::MONTH_W-1:0]       month,
	output logic [mtc_pkg::DAY_W-1:0]         day,
	output logic [mtc_pkg::WEEKDAY_W-1:0]     weekday
);
	import mtc_pkg::*;

	logic [DAYS_W-1:0]   days_s3;
	logic [32:0]         cyc_prod_s3;
	logic [32:0]         wk_prod_s3;

	logic [CYCLE_W-1:0]  cycles_s4;
	logic [REM_W-1:0]    rem_s4;
	logic [WEEKDAY_W-1:0] weekday_s4;

	logic [YEAR_W-1:0]   year_s5;
	logic [DOY_W-1:0]    doy_s5;
	logic                leap_s5;
	logic [WEEKDAY_W-1:0] weekday_s5;

	logic [YEAR_W-1:0]   year_s6;
	logic [MONTH_W-1:0]  month_s6;
	logic [DAY_W-1:0]    day_s6;
	logic [WEEKDAY_W-1:0] weekday_s6;

	logic [CYCLE_W-1:0]  cycles_c;
	logic [DAYS_W-1:0]   week_q_c;
	logic [DAYS_W-1:0]   rem_full_c;
	logic [DAYS_W-1:0]   wk_full_c;
	logic [1:0]          yoff_c;
	logic [REM_W-1:0]    doy_full_c;
	month_tbl_t          tbl_c;
	logic [MONTH_W-1:0]  month_c;
	logic [DOY_W-1:0]    day_full_c;

	always_ff @(posedge clk) begin
		if (en) begin
			days_s3     <= days;
			cyc_prod_s3 <= 33'(days) * 33'(RCP_CYCLE);
			wk_prod_s3  <= 33'(days) * 33'(RCP_WEEK);
		end
	end

	always_comb begin
		cycles_c   = cyc_prod_s3[SH_CYCLE +: CYCLE_W];
		week_q_c   = {2'b00, wk_prod_s3[32:SH_WEEK]};
		rem_full_c = days_s3 - DAYS_W'(cycles_c) * DAYS_W'(DAYS_PER_CYCLE);
		wk_full_c  = days_s3 - week_q_c * DAYS_W'(DAYS_PER_WEEK);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cycles_s4  <= cycles_c;
			rem_s4     <= rem_full_c[REM_W-1:0];
			weekday_s4 <= wk_full_c[WEEKDAY_W-1:0];
		end
	end

	always_comb begin
		priority if (rem_s4 >= REM_W'(YEAR3_START)) begin
			yoff_c     = 2'd3;
			doy_full_c = rem_s4 - REM_W'(YEAR3_START);
		end else if (rem_s4 >= REM_W'(YEAR2_START)) begin
			yoff_c     = 2'd2;
			doy_full_c = rem_s4 - REM_W'(YEAR2_START);
		end else if (rem_s4 >= REM_W'(YEAR1_START)) begin
			yoff_c     = 2'd1;
			doy_full_c = rem_s4 - REM_W'(YEAR1_START);
		end else begin
			yoff_c     = 2'd0;
			doy_full_c = rem_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s5    <= YEAR_W'(YEAR_BASE) + {3'b000, cycles_s4, 2'b00} + YEAR_W'(yoff_c);
			doy_s5     <= doy_full_c[DOY_W-1:0];
			leap_s5    <= (yoff_c == 2'd0);
			weekday_s5 <= weekday_s4;
		end
	end

	// last month whose first day is not past the day of the year
	always_comb begin
		tbl_c   = leap_s5 ? LEAP_FIRST : COMMON_FIRST;
		month_c = '0;
		for (int k = 1; k < 12; k++) begin
			if (tbl_c[k] <= doy_s5)
				month_c = MONTH_W'(k);
		end
		day_full_c = doy_s5 - tbl_c[month_c] + DOY_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s6    <= year_s5;
			month_s6   <= month_c;
			day_s6     <= day_full_c[DAY_W-1:0];
			weekday_s6 <= weekday_s5;
		end
	end

	assign year    = year_s6;
	assign month   = month_s6;
	assign day     = day_s6;
	assign weekday = weekday_s6;

endmodule

`default_nettype wire

@@ sv/mtc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mtc_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_tvalid,
	input wire                               s_tready,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [mtc_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import mtc_pkg::*;

	// a held output beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:11] <= 4'd11 && m_tdata[19:15] != 5'd0 &&
			m_tdata[22:20] <= 3'd6 && m_tdata[27:23] <= 5'd23 &&
			m_tdata[33:28] <= 6'd59 && m_tdata[39:34] <= 6'd59)
		else $error("output field out of range");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_free_in: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused with empty output");

endmodule

bind mac_timestamp_to_calendar_top mtc_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import mtc_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 5000;

	// same bit layout as m_tdata, year in the lowest bits
	typedef struct packed {
		logic [SECOND_W-1:0]  second;
		logic [MINUTE_W-1:0]  minute;
		logic [HOUR_W-1:0]    hour;
		logic [WEEKDAY_W-1:0] weekday;
		logic [DAY_W-1:0]     day;
		logic [MONTH_W-1:0]   month;
		logic [YEAR_W-1:0]    year;
	} cal_t;

	typedef struct {
		logic [SECONDS_W-1:0] secs;
		cal_t                 cal;
	} stamp_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [SHIFT_W-1:0]    cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic [SECONDS_W-1:0]  s_tdata   = '0;
	logic                  m_tready  = 1'b0;
	wire                   cfg_ready;
	wire                   s_tready;
	wire                   m_tvalid;
	wire [OUT_DATA_W-1:0]  m_tdata;

	logic [SECONDS_W-1:0]  stamp_src [$];
	stamp_t                cal_due [$];
	logic [SHIFT_W-1:0]    shift_now = SHIFT_RESET;
	int                    s_idle_pct = 33;
	int                    r_idle_pct = 78;
	int                    hold_reqs = 0;
	int                    hold_seen = 0;
	int                    hold_left = 0;
	int                    quiet_cycles = 0;
	int                    errors = 0;
	cal_t                  got_cal;
	stamp_t                due_head;

	logic [SECONDS_W-1:0]  edge_secs [24] = '{
		32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd82799, 32'd82800,
		32'd86399, 32'd86400, 32'd518400, 32'd5097600, 32'd5184000,
		32'd31622399, 32'd31622400, 32'd63072000, 32'd63158400,
		32'd94608000, 32'd94694400, 32'd126230399, 32'd126230400,
		32'd4294944000, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
	};

	mac_timestamp_to_calendar_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic cal_t calendar_of(logic [SECONDS_W-1:0] secs,
	                                     logic [SHIFT_W-1:0] shift);
		int unsigned days, sod, hh, rest, cyc, rem, yoff, doy, m;
		month_tbl_t  tbl;
		cal_t        c;
		days = secs / SECS_PER_DAY;
		sod  = secs - days * SECS_PER_DAY;
		hh   = sod / SECS_PER_HOUR;
		rest = sod - hh * SECS_PER_HOUR;
		cyc  = days / DAYS_PER_CYCLE;
		rem  = days - cyc * DAYS_PER_CYCLE;
		if (rem >= YEAR3_START) begin
			yoff = 3;
			doy  = rem - YEAR3_START;
		end else if (rem >= YEAR2_START) begin
			yoff = 2;
			doy  = rem - YEAR2_START;
		end else if (rem >= YEAR1_START) begin
			yoff = 1;
			doy  = rem - YEAR1_START;
		end else begin
			yoff = 0;
			doy  = rem;
		end
		// first year of each four-year cycle is the leap year
		tbl = (yoff == 0) ? LEAP_FIRST : COMMON_FIRST;
		m = 0;
		for (int k = 1; k < 12; k++)
			if (tbl[k] <= doy)
				m = k;
		c.year    = YEAR_W'(YEAR_BASE + 4 * cyc + yoff);
		c.month   = MONTH_W'(m);
		c.day     = DAY_W'(doy - tbl[m] + 1);
		c.weekday = WEEKDAY_W'(days % DAYS_PER_WEEK);
		c.hour    = HOUR_W'((hh + shift) % HOURS_PER_DAY);
		c.minute  = MINUTE_W'(rest / SECS_PER_MIN);
		c.second  = SECOND_W'(rest % SECS_PER_MIN);
		return c;
	endfunction

	function automatic logic [SECONDS_W-1:0] random_stamp();
		int unsigned dayn, off, cyc, yoff, k, start;
		logic [SECONDS_W-1:0] t;
		case ($urandom_range(0, 5))
			0, 1: t = $urandom();
			2: begin
				dayn = $urandom_range(0, 49709);
				case ($urandom_range(0, 3))
					0: off = 0;
					1: off = SECS_PER_DAY - 1;
					2: off = 82800 + $urandom_range(0, 3599);
					default: off = $urandom_range(0, SECS_PER_DAY - 1);
				endcase
				t = dayn * SECS_PER_DAY + off;
			end
			3, 4: begin
				// land on or just before a month or year boundary
				cyc  = $urandom_range(0, 33);
				yoff = $urandom_range(0, 3);
				k    = $urandom_range(0, 11);
				case (yoff)
					0: start = 0;
					1: start = YEAR1_START;
					2: start = YEAR2_START;
					default: start = YEAR3_START;
				endcase
				dayn = cyc * DAYS_PER_CYCLE + start +
				       ((yoff == 0) ? LEAP_FIRST[k] : COMMON_FIRST[k]);
				if ($urandom_range(0, 1) && dayn > 0)
					dayn--;
				t = dayn * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
			end
			default: t = 32'hFFFF_FFFF - $urandom_range(0, 50000000);
		endcase
		return t;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got,
	                           logic [SECONDS_W-1:0] secs);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch for %0d s: expected %0d, actual %0d",
			         $time, name, secs, want, got);
		end
	endtask

	// driver: record each accepted beat, then offer the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				cal_due.push_back('{secs: s_tdata, cal: calendar_of(s_tdata, shift_now)});
			if (stamp_src.size() > 0 && $urandom_range(0, 99) >= s_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= stamp_src.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: check the output beat, then decide ready for the next edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_cal = m_tdata;
				if (cal_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat: expected none, actual %h", $time, m_tdata);
				end else begin
					due_head = cal_due.pop_front();
					check_field("year", due_head.cal.year, got_cal.year, due_head.secs);
					check_field("month", due_head.cal.month, got_cal.month, due_head.secs);
					check_field("day", due_head.cal.day, got_cal.day, due_head.secs);
					check_field("weekday", due_head.cal.weekday, got_cal.weekday,
					            due_head.secs);
					check_field("hour", due_head.cal.hour, got_cal.hour, due_head.secs);
					check_field("minute", due_head.cal.minute, got_cal.minute, due_head.secs);
					check_field("second", due_head.cal.second, got_cal.second, due_head.secs);
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (hold_seen != hold_reqs) begin
				// hold off long enough for the pipeline to back up into the input
				hold_seen <= hold_reqs;
				hold_left <= HOLD_CYCLES;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= r_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic settle();
		while (stamp_src.size() > 0 || s_tvalid || cal_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_shift(logic [SHIFT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shift_now = value;
		@(negedge clk);
	endtask

	task automatic run_phase(int s_pct, int r_pct, int count, bit pressure);
		s_idle_pct = s_pct;
		r_idle_pct = r_pct;
		for (int i = 0; i < count; i++)
			stamp_src.push_back(random_stamp());
		if (pressure)
			hold_reqs++;
		settle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (edge_secs[i])
			stamp_src.push_back(edge_secs[i]);
		run_phase(33, 78, 250, 1'b0);
		set_shift(5'd0);
		run_phase(33, 78, 250, 1'b1);
		set_shift(5'd23);
		run_phase(78, 33, 280, 1'b0);
		set_shift(5'd31);
		run_phase(78, 33, 280, 1'b1);
		set_shift(5'd24);
		run_phase(0, 0, 280, 1'b0);
		set_shift(SHIFT_W'($urandom_range(2, 22)));
		run_phase(0, 0, 280, 1'b1);
		if (cal_due.size() != 0) begin
			errors++;
			$display("%0t: results missing: expected 0 pending, actual %0d",
			         $time, cal_due.size());
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
